// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 31;
  localparam int STAMP_W  = 32;
  localparam int CAP_W    = 5;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // word index of each register (byte address bit 2)
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic               opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lfu_in_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } lfu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lfu_state_t;

  typedef struct packed {
    logic clear;
    logic eval;
  } lfu_scan_ctl_t;

  typedef struct packed {
    logic match_found;
    logic free_found;
    logic victim_found;
  } lfu_scan_flags_t;

endpackage

// ===== sv/lfu_cfg.sv =====
module lfu_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [lfu_pkg::CAP_W-1:0]    capacity
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_en && (paddr[2] == REG_CAPACITY)) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY: prdata = DATA_W'(capacity_r);
      default:      prdata = '0;
    endcase
  end

  assign capacity = capacity_r;

endmodule

// ===== sv/lfu_scan.sv =====
module lfu_scan #(
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfu_pkg::lfu_scan_ctl_t        ctl,
  input  logic [IDX_W-1:0]              idx,
  input  logic                          slot_valid,
  input  logic [KEY_BITS-1:0]           probe_key,
  input  logic [KEY_BITS-1:0]           slot_key,
  input  logic [lfu_pkg::VALUE_W-1:0]   slot_value,
  input  logic [COUNT_BITS-1:0]         slot_count,
  input  logic [lfu_pkg::STAMP_W-1:0]   slot_stamp,
  output lfu_pkg::lfu_scan_flags_t      flags,
  output logic [IDX_W-1:0]              match_idx,
  output logic [lfu_pkg::VALUE_W-1:0]   match_value,
  output logic [COUNT_BITS-1:0]         match_count,
  output logic [IDX_W-1:0]              free_idx,
  output logic [IDX_W-1:0]              victim_idx,
  output logic [KEY_BITS-1:0]           victim_key
);
  import lfu_pkg::*;

  lfu_scan_flags_t      flags_r, flags_nxt;
  logic [IDX_W-1:0]     match_idx_r, match_idx_nxt;
  logic [VALUE_W-1:0]   match_value_r, match_value_nxt;
  logic [COUNT_BITS-1:0] match_count_r, match_count_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]     victim_idx_r, victim_idx_nxt;
  logic [KEY_BITS-1:0]  victim_key_r, victim_key_nxt;
  logic [COUNT_BITS-1:0] victim_count_r, victim_count_nxt;
  logic [STAMP_W-1:0]   victim_stamp_r, victim_stamp_nxt;
  logic                 better;

  // lower count wins, then older stamp; equal keeps the earlier slot
  assign better = !flags_r.victim_found || (slot_count < victim_count_r) ||
                  ((slot_count == victim_count_r) && (slot_stamp < victim_stamp_r));

  always_comb begin
    flags_nxt        = flags_r;
    match_idx_nxt    = match_idx_r;
    match_value_nxt  = match_value_r;
    match_count_nxt  = match_count_r;
    free_idx_nxt     = free_idx_r;
    victim_idx_nxt   = victim_idx_r;
    victim_key_nxt   = victim_key_r;
    victim_count_nxt = victim_count_r;
    victim_stamp_nxt = victim_stamp_r;
    if (ctl.clear) begin
      flags_nxt = '0;
    end else if (ctl.eval) begin
      if (!slot_valid) begin
        if (!flags_r.free_found) begin
          flags_nxt.free_found = 1'b1;
          free_idx_nxt         = idx;
        end
      end else begin
        if ((slot_key == probe_key) && !flags_r.match_found) begin
          flags_nxt.match_found = 1'b1;
          match_idx_nxt         = idx;
          match_value_nxt       = slot_value;
          match_count_nxt       = slot_count;
        end
        if (better) begin
          flags_nxt.victim_found = 1'b1;
          victim_idx_nxt         = idx;
          victim_key_nxt         = slot_key;
          victim_count_nxt       = slot_count;
          victim_stamp_nxt       = slot_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r    <= match_idx_nxt;
    match_value_r  <= match_value_nxt;
    match_count_r  <= match_count_nxt;
    free_idx_r     <= free_idx_nxt;
    victim_idx_r   <= victim_idx_nxt;
    victim_key_r   <= victim_key_nxt;
    victim_count_r <= victim_count_nxt;
    victim_stamp_r <= victim_stamp_nxt;
  end

  assign flags       = flags_r;
  assign match_idx   = match_idx_r;
  assign match_value = match_value_r;
  assign match_count = match_count_r;
  assign free_idx    = free_idx_r;
  assign victim_idx  = victim_idx_r;
  assign victim_key  = victim_key_r;

  a_victim_when_match : assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.match_found |-> flags_r.victim_found)
    else $error("match recorded without a victim candidate");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (flags_r == '0))
    else $error("scan flags survived a clear");

  a_free_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r.free_found && !ctl.clear) |=> $stable(free_idx_r))
    else $error("first free slot moved during a pass");

endmodule

// ===== sv/lfu_cache_store.sv =====
// One item is in flight at a time: an input beat is taken only in the idle state, and the
//   pace is set by the single read port of the slot memory: in the scan state one slot is
//   read per cycle, then the last read is evaluated, then the chosen slot is written back
//   and the result beat registered (held while a result beat is stalled), and the idle
//   state takes the next beat.
// Reset (rst_n low, synchronous): all slots invalid, use clock and resident count zero,
//   capacity zero; slot memory contents are left as they are.
module lfu_cache_store #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lfu_pkg::lfu_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lfu_pkg::lfu_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = STAMP_W + COUNT_BITS + VALUE_W + KEY_BITS;

  typedef struct packed {
    logic [STAMP_W-1:0]    stamp;
    logic [COUNT_BITS-1:0] count;
    logic [VALUE_W-1:0]    value;
    logic [KEY_BITS-1:0]   key;
  } slot_word_t;

  logic [CAP_W-1:0]   capacity;
  lfu_state_t         state_r, state_nxt;

  logic               op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_W-1:0] val_r;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_en;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  slot_word_t         rdata_r;
  logic [WORD_W-1:0]  mem [ENTRIES];

  logic [ENTRIES-1:0] slot_valid_r, slot_valid_nxt;
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;
  logic [CNT_W-1:0]   resident_r, resident_nxt;

  lfu_out_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  lfu_scan_ctl_t      scan_ctl;
  lfu_scan_flags_t    flags;
  logic [IDX_W-1:0]   match_idx, free_idx, victim_idx;
  logic [VALUE_W-1:0] match_value;
  logic [COUNT_BITS-1:0] match_count;
  logic [KEY_BITS-1:0] victim_key;

  logic               accept;
  logic               scan_done;
  logic               commit;
  logic               out_free;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic               wb_we;
  logic [IDX_W-1:0]   wb_addr;
  slot_word_t         wb_word;

  lfu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lfu_scan #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .idx         (rd_idx_r),
    .slot_valid  (slot_valid_r[rd_idx_r]),
    .probe_key   (key_r),
    .slot_key    (rdata_r.key),
    .slot_value  (rdata_r.value),
    .slot_count  (rdata_r.count),
    .slot_stamp  (rdata_r.stamp),
    .flags       (flags),
    .match_idx   (match_idx),
    .match_value (match_value),
    .match_count (match_count),
    .free_idx    (free_idx),
    .victim_idx  (victim_idx),
    .victim_key  (victim_key)
  );

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_en     = (state_r == ST_SCAN) && (cnt_r < CNT_W'(ENTRIES));
  assign scan_done = rd_vld_r && (rd_idx_r == IDX_W'(ENTRIES - 1));
  assign commit    = (state_r == ST_WRITE) && out_free;

  assign scan_ctl.clear = accept;
  assign scan_ctl.eval  = rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_done) state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall = 1'b1;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
      end
      ST_SCAN: begin
        if (rd_en) cnt_nxt = cnt_r + 1'b1;
      end
      ST_WRITE: begin
        cnt_nxt = cnt_r;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      op_r  <= in_data.opcode;
      key_r <= KEY_BITS'(in_data.key);
      val_r <= in_data.value;
    end
  end

  // slot memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= slot_word_t'(mem[cnt_r[IDX_W-1:0]]);
    end
    if (wb_we) begin
      mem[wb_addr] <= WORD_W'(wb_word);
    end
  end

  always_comb begin
    cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    full    = (CMP_W'(resident_r) >= cap_eff) || !flags.free_found;
  end

  // write-back and result
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    use_clock_nxt  = use_clock_r;
    resident_nxt   = resident_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    wb_we          = 1'b0;
    wb_addr        = free_idx;
    wb_word.key    = key_r;
    wb_word.value  = val_r;
    wb_word.count  = COUNT_BITS'(1);
    wb_word.stamp  = use_clock_r + 1'b1;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (cap_eff != '0) begin
        if (flags.match_found) begin
          out_nxt.hit   = 1'b1;
          wb_we         = 1'b1;
          wb_addr       = match_idx;
          wb_word.count = (&match_count) ? match_count : match_count + 1'b1;
          use_clock_nxt = use_clock_r + 1'b1;
          if (op_r == OP_GET) begin
            out_nxt.read_value = match_value;
            wb_word.value      = match_value;
          end
        end else if (op_r == OP_PUT) begin
          if (full && flags.victim_found) begin
            // evict in place: resident count is unchanged
            out_nxt.evicted     = 1'b1;
            out_nxt.evicted_key = KEY_W'(victim_key);
            wb_we               = 1'b1;
            wb_addr             = victim_idx;
            use_clock_nxt       = use_clock_r + 1'b1;
          end else if (flags.free_found) begin
            wb_we                    = 1'b1;
            wb_addr                  = free_idx;
            slot_valid_nxt[free_idx] = 1'b1;
            resident_nxt             = resident_r + 1'b1;
            use_clock_nxt            = use_clock_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      use_clock_r  <= '0;
      resident_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      use_clock_r  <= use_clock_nxt;
      resident_r   <= resident_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_resident_matches_valid : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == 32'(resident_r))
    else $error("resident count disagrees with slot valid bits");

  a_one_item_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second item taken while one is in flight");

  a_write_only_on_commit : assert property (@(posedge clk) disable iff (!rst_n)
    wb_we |-> (commit && (cap_eff != '0)))
    else $error("slot memory written outside write-back");

  a_evict_is_put_miss : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && out_nxt.evicted) |-> (op_r == OP_PUT && !flags.match_found))
    else $error("eviction on a hit or a get");

endmodule

// ===== dv/lfu_cache_store_test.sv =====
`timescale 1ns / 100ps

module lfu_cache_store_test;
  import lfu_pkg::*;

  localparam int SLOTS     = 16;
  localparam int SCAN_WAIT = SLOTS + 4;

  // Shadow copy of the cache: predicts one response per accepted request.
  class cache_predictor;
    logic [CAP_W-1:0]   capacity;
    bit                 slot_used  [SLOTS];
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VALUE_W-1:0] slot_value [SLOTS];
    logic [15:0]        slot_uses  [SLOTS];
    logic [STAMP_W-1:0] slot_stamp [SLOTS];
    logic [STAMP_W-1:0] use_clock;
    int                 resident;
    lfu_out_t           pending_results[$];
    int                 mismatches;

    function new();
      capacity = '0;
      use_clock = '0;
      resident = 0;
      mismatches = 0;
      foreach (slot_used[s]) slot_used[s] = 0;
    endfunction

    task flag_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    function void bump(int s);
      if (slot_uses[s] != 16'hFFFF) slot_uses[s]++;
      use_clock++;
      slot_stamp[s] = use_clock;
    endfunction

    function void take_request(lfu_in_t req);
      lfu_out_t rsp;
      int       limit;
      int       match;
      int       free_slot;
      int       victim;
      int       dest;
      rsp = '0;
      match = -1;
      free_slot = -1;
      victim = -1;
      dest = -1;
      limit = (capacity > SLOTS) ? SLOTS : int'(capacity);
      if (limit != 0) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_used[s]) begin
            if (free_slot < 0) free_slot = s;
            continue;
          end
          if (slot_key[s] == req.key && match < 0) match = s;
          if (victim < 0 || slot_uses[s] < slot_uses[victim] ||
              (slot_uses[s] == slot_uses[victim] && slot_stamp[s] < slot_stamp[victim]))
            victim = s;
        end
        if (match >= 0) begin
          rsp.hit = 1'b1;
          if (req.opcode == OP_GET) rsp.read_value = slot_value[match];
          else slot_value[match] = req.value;
          bump(match);
        end else if (req.opcode == OP_PUT) begin
          if (resident >= limit || free_slot < 0) begin
            if (victim >= 0) begin
              rsp.evicted = 1'b1;
              rsp.evicted_key = slot_key[victim];
              slot_used[victim] = 0;
              if (resident > 0) resident--;
              dest = victim;
            end else begin
              dest = free_slot;
            end
          end else begin
            dest = free_slot;
          end
          if (dest >= 0) begin
            slot_used[dest] = 1;
            slot_key[dest] = req.key;
            slot_value[dest] = req.value;
            slot_uses[dest] = 16'd1;
            use_clock++;
            slot_stamp[dest] = use_clock;
            resident++;
          end
        end
      end
      pending_results.push_back(rsp);
    endfunction

    task check_response(lfu_out_t got);
      lfu_out_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch("response with no request outstanding", longint'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
          flag_mismatch("hit", longint'(got.hit), longint'(want.hit));
        if (got.read_value !== want.read_value)
          flag_mismatch("read_value", longint'(got.read_value), longint'(want.read_value));
        if (got.evicted !== want.evicted)
          flag_mismatch("evicted", longint'(got.evicted), longint'(want.evicted));
        if (got.evicted_key !== want.evicted_key)
          flag_mismatch("evicted_key", longint'(got.evicted_key), longint'(want.evicted_key));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lfu_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  lfu_out_t            out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cache_predictor predictor = new();
  bit             steady;
  logic [KEY_W-1:0] key_pool[24];

  lfu_cache_store dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("** lfu_cache_store: FAILED **");
    $finish;
  end

  function automatic int pick_wait();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    lfu_in_t req;
    int      gap;
    req.opcode = op;
    req.key = key;
    req.value = value;
    gap = pick_wait();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predictor.take_request(req);
  endtask

  // drop valid and hold until every response is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predictor.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [DATA_W-1:0] word;
    drain();
    repeat (SCAN_WAIT) @(posedge clk);
    word = $urandom;
    word[CAP_W-1:0] = cap;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    predictor.capacity = cap;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // response side: stall each beat for a drawn number of valid cycles
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_wait();
      @(negedge clk);
      out_stall <= (n != 0);
      forever begin
        @(posedge clk);
        if (out_valid === 1'b1 && !out_stall) break;
        if (out_valid === 1'b1) n--;
        @(negedge clk);
        out_stall <= (n != 0);
      end
      predictor.check_response(out_data);
    end
  end

  initial begin
    logic [CAP_W-1:0] caps[8];
    int               limit;
    int               pool_size;
    logic [KEY_W-1:0] key;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled cache: everything misses, nothing sticks
    write_capacity(5'd0);
    send_request(OP_GET, 16'h0000, 31'h0);
    send_request(OP_PUT, 16'hFFFF, 31'h7FFF_FFFF);

    // two entries: hits, put update, eviction by lowest count
    write_capacity(5'd2);
    send_request(OP_PUT, 16'h0000, 31'h0);
    send_request(OP_PUT, 16'hFFFF, 31'h7FFF_FFFF);
    send_request(OP_GET, 16'h0000, 31'h7FFF_FFFF);
    send_request(OP_PUT, 16'h1234, 31'h5555_5555);
    send_request(OP_GET, 16'hFFFF, 31'h0);
    send_request(OP_PUT, 16'h0000, 31'h2AAA_AAAA);
    send_request(OP_GET, 16'h0000, 31'h0);
    send_request(OP_PUT, 16'h00FF, 31'h1);

    // above the slot count: behaves as full size
    write_capacity(5'd31);
    for (int i = 0; i < 5; i++) send_request(OP_PUT, 16'(16'hA000 + i), 31'(31'h100 + i));

    // lowered below what is resident: surplus stays, puts evict one each
    write_capacity(5'd3);
    send_request(OP_GET, 16'h0000, 31'h0);
    send_request(OP_PUT, 16'hBEEF, 31'h3);
    send_request(OP_PUT, 16'hBEF0, 31'h4);
    send_request(OP_GET, 16'hA004, 31'h0);

    caps = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd17, 5'd2, 5'd8, 5'd16};
    for (int phase = 0; phase < 8; phase++) begin
      caps[7] = (phase == 7) ? 5'($urandom_range(0, 31)) : caps[7];
      write_capacity(caps[phase]);
      steady = (phase % 3 == 2);
      limit = (caps[phase] > SLOTS) ? SLOTS : int'(caps[phase]);
      pool_size = (limit + 4 > 24) ? 24 : limit + 4;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 65535));
      key_pool[0] = (phase % 2 == 0) ? 16'h0000 : 16'hFFFF;
      for (int i = 0; i < 100; i++) begin
        if (i == 50) drain();
        if (i == 70) steady = !steady;
        if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = 16'($urandom_range(0, 65535));
        send_request(1'($urandom_range(0, 1)), key, 31'($urandom));
      end
    end

    steady = 1'b0;
    drain();
    repeat (SCAN_WAIT * 2) @(posedge clk);
    if (predictor.pending_results.size() != 0)
      predictor.flag_mismatch("responses missing at end", 0,
                              longint'(predictor.pending_results.size()));
    if (predictor.mismatches == 0) begin
      $display("** lfu_cache_store: PASSED **");
    end else begin
      $display("** lfu_cache_store: FAILED **");
    end
    $finish;
  end

endmodule
